[rtl/button_debounce_event_queue_defines.svh]
`ifndef BUTTON_DEBOUNCE_EVENT_QUEUE_DEFINES_SVH
`define BUTTON_DEBOUNCE_EVENT_QUEUE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BDEQ_ASSERT_AT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdeq assertion failed");

// next-cycle implication, disabled in reset
`define BDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdeq assertion failed");

`endif

[rtl/bdeq_pkg.sv]
package bdeq_pkg;

    localparam int SLOT_COUNT = 7;
    localparam int PIN_W      = 5;
    localparam int TICKS_W    = 7;
    localparam int CODE_W     = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd7;
    localparam logic [TICKS_W-1:0]   DEBOUNCE_RESET = 7'd70;
    localparam logic [2:0]           SLOT_TRIG_R    = 3'd5;
    localparam logic [2:0]           SLOT_TRIG_L    = 3'd6;
    localparam logic [CODE_W-1:0]    CODE_NONE      = 4'd0;
    localparam logic [CODE_W-1:0]    CODE_TRIG_R    = 4'd11;
    localparam logic [CODE_W-1:0]    CODE_TRIG_L    = 4'd12;
    localparam logic [CODE_W-1:0]    CODE_MAX       = 4'd12;

    typedef enum logic [1:0] {
        CMD_EDGE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_POP  = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd                    cmd;
        logic [PIN_W-1:0]        pin_number;
        logic [SLOT_COUNT-1:0]   pin_levels;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic              queue_full;
        logic              queue_empty;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } t_push;

    function automatic logic [CODE_W-1:0] code_for(input logic [2:0] slot, input logic level);
        logic [CODE_W-1:0] code;
        if (slot == SLOT_TRIG_R) begin
            code = level ? CODE_NONE : CODE_TRIG_R;
        end else if (slot == SLOT_TRIG_L) begin
            code = level ? CODE_NONE : CODE_TRIG_L;
        end else begin
            code = {slot, 1'b0} + (level ? 4'd2 : 4'd1);
        end
        return code;
    endfunction

endpackage

[rtl/button_debounce_event_queue.sv]
// an accepted command is registered in r_in_valid and then in r_done, which drives the result strobe
// throughput: one command per cycle, busy stays low
// the queue memory read and the flags are registered with the result
// synchronous active-low reset empties the queue, clears debounce state and
// restores default pin map and debounce ticks; results cannot be stalled
module button_debounce_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  bdeq_pkg::t_item                   i_item,
    output logic                              o_done,
    output bdeq_pkg::t_result                 o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bdeq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bdeq_pkg::TICKS_W-1:0]      i_cfg_data
);

    logic                  r_in_valid;
    bdeq_pkg::t_item       r_item;
    logic                  r_done;
    bdeq_pkg::t_q_status   q_status;
    bdeq_pkg::t_push       push;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        r_item <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_done     <= r_in_valid;
        end
    end

    bdeq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_go        (r_in_valid),
        .i_item      (r_item),
        .i_status    (q_status),
        .o_push      (push)
    );

    bdeq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pop    (r_in_valid && (r_item.cmd == bdeq_pkg::CMD_POP)),
        .i_push   (push),
        .o_status (q_status),
        .o_result (o_result)
    );

    assign o_done = r_done;

endmodule

[rtl/bdeq_ctrl.sv]
module bdeq_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [bdeq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bdeq_pkg::TICKS_W-1:0]        i_cfg_data,
    input  logic                                i_go,
    input  bdeq_pkg::t_item                     i_item,
    input  bdeq_pkg::t_q_status                 i_status,
    output bdeq_pkg::t_push                     o_push
);

    logic [bdeq_pkg::PIN_W-1:0]   r_slot_pin [bdeq_pkg::SLOT_COUNT];
    logic [bdeq_pkg::TICKS_W-1:0] r_debounce;

    logic [2:0]                   r_slot,   n_slot;
    logic                         r_level,  n_level;
    logic                         r_active, n_active;
    logic [bdeq_pkg::TICKS_W-1:0] r_count,  n_count;

    logic       found;
    logic [2:0] match_slot;

    // lowest matching slot wins
    always_comb begin
        found      = 1'b0;
        match_slot = '0;
        for (int i = bdeq_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
            if (i_item.pin_number == r_slot_pin[i]) begin
                found      = 1'b1;
                match_slot = 3'(i);
            end
        end
    end

    always_comb begin
        n_slot      = r_slot;
        n_level     = r_level;
        n_active    = r_active;
        n_count     = r_count;
        o_push      = '0;
        o_push.code = bdeq_pkg::code_for(r_slot, r_level);
        if (i_go) begin
            unique case (i_item.cmd)
                bdeq_pkg::CMD_EDGE: begin
                    if (!i_status.full && found) begin
                        n_slot   = match_slot;
                        n_level  = i_item.pin_levels[match_slot];
                        n_active = 1'b1;
                        n_count  = r_debounce;
                    end
                end
                bdeq_pkg::CMD_TICK: begin
                    if (r_active) begin
                        if (r_count <= 7'd1) begin
                            n_active     = 1'b0;
                            n_count      = '0;
                            o_push.valid = (i_item.pin_levels[r_slot] == r_level);
                        end else begin
                            n_count = r_count - 7'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bdeq_pkg::SLOT_COUNT; i++) begin
                r_slot_pin[i] <= 5'(i);
            end
            r_debounce <= bdeq_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bdeq_pkg::CFG_DEBOUNCE) begin
                r_debounce <= i_cfg_data;
            end else begin
                r_slot_pin[i_cfg_index] <= i_cfg_data[bdeq_pkg::PIN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_level  <= 1'b0;
            r_active <= 1'b0;
            r_count  <= '0;
        end else begin
            r_slot   <= n_slot;
            r_level  <= n_level;
            r_active <= n_active;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/bdeq_queue.sv]
module bdeq_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_pop,
    input  bdeq_pkg::t_push                  i_push,
    output bdeq_pkg::t_q_status              o_status,
    output bdeq_pkg::t_result                o_result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [bdeq_pkg::CODE_W-1:0] mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] r_rd, n_rd;
    logic [PTR_W-1:0] r_wr, n_wr;
    logic             r_full, r_empty;
    logic [bdeq_pkg::CODE_W-1:0] r_code;
    logic             push_ok, pop_ok;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign o_status.full  = (next_ptr(r_wr) == r_rd);
    assign o_status.empty = (r_rd == r_wr);

    assign push_ok = i_push.valid && !o_status.full;
    assign pop_ok  = i_pop && !o_status.empty;

    assign n_wr = push_ok ? next_ptr(r_wr) : r_wr;
    assign n_rd = pop_ok  ? next_ptr(r_rd) : r_rd;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            mem[r_wr] <= i_push.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_ok) begin
            r_code <= mem[r_rd];
        end else begin
            r_code <= bdeq_pkg::CODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_full  <= 1'b0;
            r_empty <= 1'b1;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_full  <= (next_ptr(n_wr) == n_rd);
            r_empty <= (n_rd == n_wr);
        end
    end

    assign o_result.event_code  = r_code;
    assign o_result.queue_full  = r_full;
    assign o_result.queue_empty = r_empty;

endmodule

[rtl/bdeq_checker.sv]
`include "button_debounce_event_queue_defines.svh"

module bdeq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input bdeq_pkg::t_result   o_result
);

    // every accepted transaction gives one done strobe, and every strobe has an accepted transaction behind it
    `BDEQ_ASSERT_AT(a_done_follows, i_clk, i_rst_n, start && !busy, ##2 o_done)
    `BDEQ_ASSERT_AT(a_done_has_cause, i_clk, i_rst_n, o_done, $past(start && !busy, 2))
    `BDEQ_ASSERT_AT(a_full_not_empty, i_clk, i_rst_n, o_done && o_result.queue_full,
        !o_result.queue_empty)
    `BDEQ_ASSERT_NEXT(a_code_range, i_clk, i_rst_n, o_done,
        $past(o_result.event_code) <= bdeq_pkg::CODE_MAX)

endmodule

bind button_debounce_event_queue bdeq_checker u_bdeq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

[tb/button_debounce_event_queue_tb.sv]
`timescale 1ns / 1ps

module button_debounce_event_queue_tb;
    import bdeq_pkg::*;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 2000;
    localparam logic [PIN_W-1:0] BENCH_PINS [SLOT_COUNT] =
        '{5'd0, 5'd1, 5'd2, 5'd3, 5'd2, 5'd5, 5'd31};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_item                i_item = '0;
    logic                 o_done;
    t_result              o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TICKS_W-1:0]   i_cfg_data = '0;

    // debounce and event queue state as the block should hold it
    logic [PIN_W-1:0]   button_pin [SLOT_COUNT];
    logic [TICKS_W-1:0] recheck_ticks;
    logic [CODE_W-1:0]  event_fifo [DEPTH];
    int                 head_idx;
    int                 tail_idx;
    logic [2:0]         armed_slot;
    logic               armed_level;
    logic               armed;
    logic [TICKS_W-1:0] ticks_left;

    t_item   stimulus_items [$];
    t_result predicted_results [$];
    t_result due_result;
    int      items_made;
    int      idle_left;
    bit      gaps_on;
    int      mismatches = 0;
    int      stall_cycles = 0;

    button_debounce_event_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void reset_button_model();
        for (int s = 0; s < SLOT_COUNT; s++) begin
            button_pin[s] = PIN_W'(s);
        end
        recheck_ticks = DEBOUNCE_RESET;
        head_idx = 0;
        tail_idx = 0;
        armed_slot = '0;
        armed_level = 1'b0;
        armed = 1'b0;
        ticks_left = '0;
    endfunction

    function automatic bit fifo_full();
        return ((tail_idx + 1) % DEPTH) == head_idx;
    endfunction

    function automatic t_result advance_button_model(t_item it);
        t_result           res;
        bit                found;
        logic [CODE_W-1:0] code;
        res.event_code = CODE_NONE;
        found = 1'b0;
        case (it.cmd)
            CMD_EDGE: begin
                if (!fifo_full()) begin
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        if (!found && button_pin[s] == it.pin_number) begin
                            found = 1'b1;
                            armed_slot = 3'(s);
                            armed_level = it.pin_levels[s];
                            armed = 1'b1;
                            ticks_left = recheck_ticks;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (armed) begin
                    if (ticks_left <= 1) begin
                        armed = 1'b0;
                        ticks_left = '0;
                        if (it.pin_levels[armed_slot] == armed_level && !fifo_full()) begin
                            // pull-up: low is a press, high a release
                            code = CODE_W'(2 * armed_slot + 1 + armed_level);
                            if (armed_slot == SLOT_TRIG_R) begin
                                code = armed_level ? CODE_NONE : CODE_TRIG_R;
                            end else if (armed_slot == SLOT_TRIG_L) begin
                                code = armed_level ? CODE_NONE : CODE_TRIG_L;
                            end
                            event_fifo[tail_idx] = code;
                            tail_idx = (tail_idx + 1) % DEPTH;
                        end
                    end else begin
                        ticks_left = ticks_left - 7'd1;
                    end
                end
            end
            CMD_POP: begin
                if (head_idx != tail_idx) begin
                    res.event_code = event_fifo[head_idx];
                    head_idx = (head_idx + 1) % DEPTH;
                end
            end
            default: begin
            end
        endcase
        res.queue_full = fifo_full();
        res.queue_empty = (head_idx == tail_idx);
        return res;
    endfunction

    function automatic int pick_idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                predicted_results.push_back(advance_button_model(i_item));
            end
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                    start <= 1'b0;
                end else if (stimulus_items.size() > 0) begin
                    start <= 1'b1;
                    i_item <= stimulus_items.pop_front();
                    idle_left <= pick_idle_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (predicted_results.size() == 0) begin
                $error("result with no transaction pending: %p", o_result);
                mismatches++;
            end else begin
                due_result = predicted_results.pop_front();
                if (o_result.event_code !== due_result.event_code) begin
                    $error("event_code expected %0d actual %0d",
                           due_result.event_code, o_result.event_code);
                    mismatches++;
                end
                if (o_result.queue_full !== due_result.queue_full) begin
                    $error("queue_full expected %0b actual %0b",
                           due_result.queue_full, o_result.queue_full);
                    mismatches++;
                end
                if (o_result.queue_empty !== due_result.queue_empty) begin
                    $error("queue_empty expected %0b actual %0b",
                           due_result.queue_empty, o_result.queue_empty);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < SLOT_COUNT) begin
            button_pin[idx] = data[PIN_W-1:0];
        end else if (idx == CFG_DEBOUNCE) begin
            recheck_ticks = data;
        end
    endtask

    // pin_style: 0 default, 1 random, 2 all on pin 31, 3 reversed, 4 bench map
    task automatic configure(input int ticks, input int pin_style);
        logic [PIN_W-1:0] p;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            case (pin_style)
                1: p = PIN_W'($urandom_range(0, 31));
                2: p = '1;
                3: p = (s == SLOT_COUNT - 1) ? '0 : PIN_W'(31 - s);
                4: p = BENCH_PINS[s];
                default: p = PIN_W'(s);
            endcase
            // upper data bits are don't-care for pin registers
            write_reg(CFG_IDX_W'(s), {2'($urandom), p});
        end
        write_reg(CFG_DEBOUNCE, TICKS_W'(ticks));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (stimulus_items.size() != 0 || start || predicted_results.size() != 0);
    endtask

    task automatic add_item(input t_cmd c, input logic [PIN_W-1:0] p,
                            input logic [SLOT_COUNT-1:0] l);
        t_item it;
        it.cmd = c;
        it.pin_number = p;
        it.pin_levels = l;
        stimulus_items.push_back(it);
        items_made++;
    endtask

    task automatic add_noise();
        add_item(t_cmd'(2'($urandom_range(0, 3))), PIN_W'($urandom), SLOT_COUNT'($urandom));
    endtask

    // edge on a mapped button followed by the ticks up to the recheck
    task automatic queue_button_sequence();
        int                    slot;
        int                    n;
        bit                    lvl;
        bit                    bounce;
        logic [SLOT_COUNT-1:0] lv;
        slot = $urandom_range(0, SLOT_COUNT - 1);
        lvl = 1'($urandom_range(0, 1));
        bounce = ($urandom_range(0, 7) == 0);
        n = (recheck_ticks == 0) ? 1 : recheck_ticks;
        lv = SLOT_COUNT'($urandom);
        lv[slot] = lvl;
        add_item(CMD_EDGE, button_pin[slot], lv);
        for (int k = 0; k < n; k++) begin
            lv = SLOT_COUNT'($urandom);
            lv[slot] = (bounce && k == n - 1) ? !lvl : lvl;
            if ($urandom_range(0, 19) == 0) begin
                add_noise();
            end
            add_item(CMD_TICK, PIN_W'($urandom), lv);
        end
    endtask

    task automatic run_phase(input int ticks, input int pin_style, input int pop_pct,
                             input int budget, input bit gaps);
        int r;
        wait_drained();
        configure(ticks, pin_style);
        @(negedge i_clk);
        gaps_on = gaps;
        items_made = 0;
        while (items_made < budget) begin
            r = $urandom_range(0, 99);
            if (r < pop_pct) begin
                add_item(CMD_POP, PIN_W'($urandom), SLOT_COUNT'($urandom));
            end else if (r < pop_pct + 8) begin
                add_noise();
            end else begin
                queue_button_sequence();
            end
        end
    endtask

    initial begin
        reset_button_model();
        gaps_on = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: slot 4 shares pin 2 with slot 2, left trigger on pin 31
        configure(2, 4);
        @(negedge i_clk);
        add_item(CMD_TICK, 5'd0, 7'h00);
        add_item(t_cmd'(2'd3), 5'd31, 7'h7f);
        add_item(CMD_EDGE, 5'd9, 7'h00);
        add_item(CMD_EDGE, 5'd0, 7'h00);
        add_item(CMD_TICK, 5'd0, 7'h00);
        add_item(CMD_TICK, 5'd0, 7'h00);
        add_item(CMD_EDGE, 5'd31, 7'h7f);
        add_item(CMD_TICK, 5'd0, 7'h7f);
        add_item(CMD_TICK, 5'd0, 7'h7f);
        add_item(CMD_EDGE, 5'd2, 7'h04);
        add_item(CMD_TICK, 5'd0, 7'h04);
        add_item(CMD_EDGE, 5'd5, 7'h00);
        add_item(CMD_TICK, 5'd0, 7'h00);
        add_item(CMD_TICK, 5'd0, 7'h00);
        add_item(CMD_EDGE, 5'd3, 7'h08);
        add_item(CMD_TICK, 5'd0, 7'h08);
        add_item(CMD_TICK, 5'd0, 7'h00);
        add_item(CMD_EDGE, 5'd1, 7'h7d);
        add_item(CMD_TICK, 5'd0, 7'h7d);
        add_item(CMD_TICK, 5'd0, 7'h7d);
        repeat (5) add_item(CMD_POP, 5'd31, 7'h00);

        run_phase(0, 0, 20, 60, 1'b1);
        run_phase(1, 1, 5, 80, 1'b1);
        run_phase(3, 2, 60, 60, 1'b0);
        run_phase(127, 0, 3, 120, 1'b1);
        run_phase(2, 3, 40, 80, 1'b1);
        run_phase(4, 1, 15, 80, 1'b0);

        // empty the queue and pop at least twice more while empty
        wait_drained();
        @(negedge i_clk);
        gaps_on = 1'b1;
        repeat (DEPTH + 1) add_item(CMD_POP, PIN_W'($urandom), SLOT_COUNT'($urandom));
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
